// ----- rtl/core/vec3_axis_rotate_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for vec3_axis_rotate
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VEC3_AXIS_ROTATE_ASSERT_SVH
`define VEC3_AXIS_ROTATE_ASSERT_SVH

// same-cycle implication
`define VRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vec3_axis_rotate: check failed");

// implication after a fixed number of cycles
`define VRA_ASSERT_DLY(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error("vec3_axis_rotate: delayed check failed");

`endif

// ----- rtl/core/vra_pkg.sv -----
// ----------------------------------------------------------------------------
// vra_pkg
// Types, constants and the arctangent table of the axis rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vra_pkg;

	localparam int COORD_BITS    = 32;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	localparam int TRIG_W     = 32;            // Q2.30 sine / cosine
	localparam int TRIG_FRAC  = 30;
	localparam int ZANG_W     = 32;            // residual angle, 2^-32 turn units
	localparam int ATAN_DEPTH = 32;
	localparam int ATAN_IDX_W = 5;
	localparam int PROD_W     = COORD_BITS + TRIG_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int RND_W      = SUM_W - TRIG_FRAC;

	// accept to result: a register per CORDIC cell, the two mixer stages, the output register
	localparam int LATENCY = CORDIC_STAGES + 3;

	localparam logic [1:0] MODE_X    = 2'd0;
	localparam logic [1:0] MODE_Y    = 2'd1;
	localparam logic [1:0] MODE_Z    = 2'd2;
	localparam logic [1:0] MODE_PASS = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0]     trig_t;
	typedef logic signed [ZANG_W-1:0]     zang_t;

	localparam trig_t GAIN_INV_Q30 = trig_t'(652032874);

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] quad;
		coord_t     cx;
		coord_t     cy;
		coord_t     cz;
	} item_t;

	typedef struct packed {
		trig_t x;
		trig_t y;
		zang_t z;
	} rot_t;

	localparam zang_t ATAN_TURNS [ATAN_DEPTH] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	function automatic zang_t atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		return ATAN_TURNS[idx];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vra_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// vra_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered, with the point riding along.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_cordic_cell import vra_pkg::*; (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire logic [ATAN_IDX_W-1:0] idx,
	input  wire logic                   vld_in,
	input  wire item_t                  item_in,
	input  wire rot_t                   rot_in,
	output logic                        vld_out,
	output item_t                       item_out,
	output rot_t                        rot_out
);

	logic  vld_q;
	item_t item_q;
	rot_t  rot_q;
	rot_t  rot_nxt;
	trig_t dx;
	trig_t dy;
	zang_t turn;

	always_comb begin
		dx   = rot_in.y >>> idx;
		dy   = rot_in.x >>> idx;
		turn = atan_turn(idx);
		if (!rot_in.z[ZANG_W-1]) begin
			rot_nxt.x = rot_in.x - dx;
			rot_nxt.y = rot_in.y + dy;
			rot_nxt.z = rot_in.z - turn;
		end else begin
			rot_nxt.x = rot_in.x + dx;
			rot_nxt.y = rot_in.y - dy;
			rot_nxt.z = rot_in.z + turn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_in;
		rot_q  <= rot_nxt;
	end

	assign vld_out  = vld_q;
	assign item_out = item_q;
	assign rot_out  = rot_q;

endmodule

`default_nettype wire

// ----- rtl/core/vra_mix.sv -----
// ----------------------------------------------------------------------------
// vra_mix
// Two-stage p*k1 + q*k2 with round half up from Q2.30 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_mix import vra_pkg::*; (
	input  wire         clk,
	input  wire coord_t p,
	input  wire coord_t q,
	input  wire trig_t  k1,
	input  wire trig_t  k2,
	output coord_t      res
);

	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);

	logic signed [PROD_W-1:0] prod_a_s1;
	logic signed [PROD_W-1:0] prod_b_s1;
	logic signed [SUM_W-1:0]  sum;
	logic signed [RND_W-1:0]  rnd_s2;

	always_comb begin
		sum = SUM_W'(prod_a_s1) + SUM_W'(prod_b_s1) + RND_HALF;
	end

	always_ff @(posedge clk) begin
		prod_a_s1 <= PROD_W'(p) * PROD_W'(k1);
		prod_b_s1 <= PROD_W'(q) * PROD_W'(k2);
		rnd_s2    <= sum[SUM_W-1:TRIG_FRAC];
	end

	// clamp to the signed coordinate range
	always_comb begin
		if (!rnd_s2[RND_W-1] && (|rnd_s2[RND_W-2:COORD_BITS-1])) begin
			res = {1'b0, {(COORD_BITS-1){1'b1}}};
		end else if (rnd_s2[RND_W-1] && !(&rnd_s2[RND_W-2:COORD_BITS-1])) begin
			res = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			res = rnd_s2[COORD_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/vec3_axis_rotate.sv -----
// ----------------------------------------------------------------------------
// vec3_axis_rotate: rotate a Q16.16 point about the X, Y or Z axis
// Path: the result strobe (done) follows the start transfer through a register
//   per CORDIC cell, the two mixer stages and the output register.
// Throughput: one point per clock, set by the cell chain; busy is low except
//   in the first cycle after reset. Reset clears all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_axis_rotate import vra_pkg::*; (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire logic [1:0]              mode,
	input  wire coord_t                  in_x,
	input  wire coord_t                  in_y,
	input  wire coord_t                  in_z,
	input  wire logic [ANGLE_BITS-1:0]  turn_angle,
	output logic                         done,
	output coord_t                       out_x,
	output coord_t                       out_y,
	output coord_t                       out_z
);

	// quadrant codes from the top two angle bits
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic ready_q;
	logic accept;

	// cell chain taps: index 0 is the input side, CORDIC_STAGES the far end
	logic  vld_c  [CORDIC_STAGES+1];
	item_t item_c [CORDIC_STAGES+1];
	rot_t  rot_c  [CORDIC_STAGES+1];

	item_t fin_item;
	rot_t  fin_rot;
	trig_t cs;
	trig_t sn;
	trig_t neg_sn;
	coord_t mix_p;
	coord_t mix_q;
	coord_t mix_u;
	coord_t mix_v;

	logic  vld_s1;
	logic  vld_s2;
	item_t item_s1;
	item_t item_s2;

	logic   done_q;
	coord_t out_x_q;
	coord_t out_y_q;
	coord_t out_z_q;

	// Hold off the first transfer in the first cycle after reset; the pipeline never
	// stalls afterwards, since the receiver takes every result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && ready_q;

	// Load the CORDIC seed: x = 1/K in Q2.30, y = 0, z = angle within the quadrant
	// scaled to 2^-32 turn units. The quadrant bits ride along with the point.
	always_comb begin
		vld_c[0]       = accept;
		item_c[0].mode = mode;
		item_c[0].quad = turn_angle[ANGLE_BITS-1 -: 2];
		item_c[0].cx   = in_x;
		item_c[0].cy   = in_y;
		item_c[0].cz   = in_z;
		rot_c[0].x     = GAIN_INV_Q30;
		rot_c[0].y     = '0;
		rot_c[0].z     = {2'b00, turn_angle[ANGLE_BITS-3:0], {(ZANG_W-ANGLE_BITS){1'b0}}};
	end

	// Advance one micro-rotation per cell per cycle.
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		vra_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (ATAN_IDX_W'(g)),
			.vld_in   (vld_c[g]),
			.item_in  (item_c[g]),
			.rot_in   (rot_c[g]),
			.vld_out  (vld_c[g+1]),
			.item_out (item_c[g+1]),
			.rot_out  (rot_c[g+1])
		);
	end

	assign fin_item = item_c[CORDIC_STAGES];
	assign fin_rot  = rot_c[CORDIC_STAGES];

	// Fold the first-quadrant result back to the full circle.
	always_comb begin
		unique case (fin_item.quad)
			QUAD_0: begin
				cs = fin_rot.x;
				sn = fin_rot.y;
			end
			QUAD_1: begin
				cs = -fin_rot.y;
				sn = fin_rot.x;
			end
			QUAD_2: begin
				cs = -fin_rot.x;
				sn = -fin_rot.y;
			end
			QUAD_3: begin
				cs = fin_rot.y;
				sn = -fin_rot.x;
			end
		endcase
		neg_sn = -sn;
	end

	// Pick the coordinate pair (u, v) that turns; the pass mode drives a
	// don't-care pair whose products are dropped at the output.
	always_comb begin
		unique case (fin_item.mode)
			MODE_X: begin
				mix_p = fin_item.cy;
				mix_q = fin_item.cz;
			end
			MODE_Y: begin
				mix_p = fin_item.cx;
				mix_q = fin_item.cz;
			end
			MODE_Z: begin
				mix_p = fin_item.cx;
				mix_q = fin_item.cy;
			end
			MODE_PASS: begin
				mix_p = fin_item.cx;
				mix_q = fin_item.cy;
			end
		endcase
	end

	// u' = u*cos - v*sin
	vra_mix u_mix_u (
		.clk (clk),
		.p   (mix_p),
		.q   (mix_q),
		.k1  (cs),
		.k2  (neg_sn),
		.res (mix_u)
	);

	// v' = u*sin + v*cos
	vra_mix u_mix_v (
		.clk (clk),
		.p   (mix_p),
		.q   (mix_q),
		.k1  (sn),
		.k2  (cs),
		.res (mix_v)
	);

	// Carry the point alongside the two mixer stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld_c[CORDIC_STAGES];
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= fin_item;
		item_s2 <= item_s1;
	end

	// Merge: the axis coordinate is copied, the other two take the mixer results; pass mode copies all three.
	always_ff @(posedge clk) begin
		unique case (item_s2.mode)
			MODE_X: begin
				out_x_q <= item_s2.cx;
				out_y_q <= mix_u;
				out_z_q <= mix_v;
			end
			MODE_Y: begin
				out_x_q <= mix_u;
				out_y_q <= item_s2.cy;
				out_z_q <= mix_v;
			end
			MODE_Z: begin
				out_x_q <= mix_u;
				out_y_q <= mix_v;
				out_z_q <= item_s2.cz;
			end
			MODE_PASS: begin
				out_x_q <= item_s2.cx;
				out_y_q <= item_s2.cy;
				out_z_q <= item_s2.cz;
			end
		endcase
	end

	assign done  = done_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;

endmodule

`default_nettype wire

// ----- rtl/core/vra_checker.sv -----
// ----------------------------------------------------------------------------
// vra_checker
// Port-level checks of transfer timing and coordinate pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vec3_axis_rotate_assert.svh"

module vra_checker import vra_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              start,
	input wire              busy,
	input wire logic [1:0]  mode,
	input wire coord_t      in_x,
	input wire coord_t      in_y,
	input wire coord_t      in_z,
	input wire              done,
	input wire coord_t      out_x,
	input wire coord_t      out_y,
	input wire coord_t      out_z
);

	`VRA_ASSERT_DLY(a_done_after_transfer, start && !busy, LATENCY, done)
	`VRA_ASSERT_IMP(a_done_has_source, done, $past(start && !busy, LATENCY))
	`VRA_ASSERT_IMP(a_pass_mode_copies, done && $past(start && !busy && mode == MODE_PASS, LATENCY), out_x == $past(in_x, LATENCY) && out_y == $past(in_y, LATENCY) && out_z == $past(in_z, LATENCY))
	`VRA_ASSERT_IMP(a_z_axis_keeps_z, done && $past(start && !busy && mode == MODE_Z, LATENCY), out_z == $past(in_z, LATENCY))

endmodule

bind vec3_axis_rotate vra_checker u_vra_checker (.*);

`default_nettype wire
